FILE: rtl/core/ptkm_pkg.sv
// ----------------------------------------------------------------------------
// ptkm_pkg
// Shared codes for the Patricia trie key map.
// ----------------------------------------------------------------------------
package ptkm_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Request operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_BIND   = 1'b1;

endpackage

FILE: rtl/core/ptkm_if.sv
// ----------------------------------------------------------------------------
// ptkm_req_if / ptkm_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ptkm_req_if #(
    parameter int KW = 32,
    parameter int VW = 32
);
    logic          valid;
    logic          ready;
    logic          operation;
    logic [KW-1:0] key;
    logic [VW-1:0] value;

    modport source (output valid, operation, key, value, input ready);
    modport sink   (input valid, operation, key, value, output ready);
endinterface

interface ptkm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        is_new;
    logic [31:0] stored_value;

    modport source (output valid, status, is_new, stored_value, input ready);
    modport sink   (input valid, status, is_new, stored_value, output ready);
endinterface

FILE: rtl/core/patricia_trie_key_map_top.sv
// ----------------------------------------------------------------------------
// patricia_trie_key_map_top
// Key-to-value map held as a big-endian Patricia trie in two on-chip RAMs.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | operation, key, value
//  rsp     | out | status, is_new, stored_value
//
//  Flow: one request at a time. Each trie step is one branch RAM read; a
//  bind also searches for the highest differing key bit and walks the trie
//  again to the splice point.
//  Reset: registers only; RAM contents are never used before being written.
//  Stalls: the result sits in an output register; the next request is taken
//  once that result is delivered.
module patricia_trie_key_map_top #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int CAPACITY    = 256
) (
    input  logic clk,
    input  logic rst_n,
    ptkm_req_if.sink   req,
    ptkm_rsp_if.source rsp
);
    localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int BW = (KEY_WIDTH > 1) ? $clog2(KEY_WIDTH) : 1;
    localparam int RW = IW + 1;           // node ref: {is_branch, index}
    localparam int CW = $clog2(CAPACITY + 1);

    // state codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_W1RD  = 4'd1;
    localparam logic [3:0] S_W1    = 4'd2;
    localparam logic [3:0] S_LRD   = 4'd3;
    localparam logic [3:0] S_LEAF  = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_W2RD  = 4'd6;
    localparam logic [3:0] S_W2    = 4'd7;
    localparam logic [3:0] S_SPLC  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // memories
    logic [KEY_WIDTH+VALUE_WIDTH-1:0] leaf_mem [CAPACITY];
    logic [BW+2*RW-1:0]               br_mem   [CAPACITY-1];

    logic [3:0]             state_reg;
    logic                   root_valid_reg;
    logic [RW-1:0]          root_reg;
    logic [CW-1:0]          leaf_cnt_reg;
    logic [CW-1:0]          br_cnt_reg;
    logic                   op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [RW-1:0]          cur_reg;      // node being visited
    logic [RW-1:0]          par_reg;      // parent branch of cur (walk 2)
    logic                   par_side_reg;
    logic                   has_par_reg;
    logic [KEY_WIDTH-1:0]   diff_reg;
    logic [BW-1:0]          hb_reg;
    logic [BW+2*RW-1:0]     br_q_reg;
    logic [BW+2*RW-1:0]     par_node_reg;
    logic [KEY_WIDTH+VALUE_WIDTH-1:0] leaf_q_reg;
    logic [1:0]             st_reg;
    logic                   new_reg;
    logic [31:0]            sv_reg;

    // decoded fields of the branch read
    logic [BW-1:0] q_bit;
    logic [RW-1:0] q_c0, q_c1, q_child;
    logic          q_side;
    assign q_bit   = br_q_reg[BW+2*RW-1 -: BW];
    assign q_c1    = br_q_reg[2*RW-1 -: RW];
    assign q_c0    = br_q_reg[RW-1:0];
    assign q_side  = key_reg[q_bit];
    assign q_child = q_side ? q_c1 : q_c0;

    logic [KEY_WIDTH-1:0] leaf_key;
    logic [VALUE_WIDTH-1:0] leaf_val;
    assign leaf_key = leaf_q_reg[KEY_WIDTH+VALUE_WIDTH-1 -: KEY_WIDTH];
    assign leaf_val = leaf_q_reg[VALUE_WIDTH-1:0];

    // value widened or cut to the 32-bit output
    function automatic logic [31:0] out32(input logic [VALUE_WIDTH-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[31:0];
    endfunction

    logic new_side;
    assign new_side = key_reg[hb_reg];

    logic [IW-1:0] li, bi;
    assign li = leaf_cnt_reg[IW-1:0];
    assign bi = br_cnt_reg[IW-1:0];

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.status = st_reg;
    assign rsp.is_new = new_reg;
    assign rsp.stored_value = sv_reg;

    // memory reads: address from the node being visited
    always_ff @(posedge clk)
    begin
        br_q_reg   <= br_mem[cur_reg[IW-1:0]];
        leaf_q_reg <= leaf_mem[cur_reg[IW-1:0]];
    end

    // memory writes on the splice or first insert
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SPLC)
        begin
            leaf_mem[li] <= {key_reg, val_reg};
            if (new_side)
                br_mem[bi] <= {hb_reg, {1'b0, li}, cur_reg};
            else
                br_mem[bi] <= {hb_reg, cur_reg, {1'b0, li}};
            if (has_par_reg)
            begin
                if (par_side_reg)
                    br_mem[par_reg[IW-1:0]] <= {par_node_reg[BW+2*RW-1 -: BW],
                        {1'b1, bi}, par_node_reg[RW-1:0]};
                else
                    br_mem[par_reg[IW-1:0]] <= {par_node_reg[BW+2*RW-1 -: RW+BW],
                        {1'b1, bi}};
            end
        end
        else if (state_reg == S_IDLE && req.valid && !root_valid_reg
                 && req.operation == ptkm_pkg::OP_BIND)
            leaf_mem[0] <= {req.key, req.value};
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            root_valid_reg <= 1'b0;
            root_reg       <= '0;
            leaf_cnt_reg   <= '0;
            br_cnt_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg  <= req.operation;
                        key_reg <= req.key;
                        val_reg <= req.value;
                        cur_reg <= root_reg;
                        new_reg <= 1'b0;
                        sv_reg  <= '0;
                        st_reg  <= ptkm_pkg::ST_NOT_FOUND;
                        if (!root_valid_reg)
                        begin
                            state_reg <= S_OUT;
                            if (req.operation == ptkm_pkg::OP_BIND)
                            begin
                                root_valid_reg <= 1'b1;
                                root_reg       <= '0;
                                leaf_cnt_reg   <= CW'(1);
                                st_reg <= ptkm_pkg::ST_OK;
                                new_reg <= 1'b1;
                                sv_reg <= out32(req.value);
                            end
                        end
                        else
                            state_reg <= root_reg[RW-1] ? S_W1RD : S_LRD;
                    end
                end
                S_W1RD: state_reg <= S_W1;
                S_W1:
                begin
                    cur_reg   <= q_child;
                    state_reg <= q_child[RW-1] ? S_W1RD : S_LRD;
                end
                S_LRD: state_reg <= S_LEAF;
                S_LEAF:
                begin
                    if (leaf_key == key_reg)
                    begin
                        st_reg <= ptkm_pkg::ST_OK;
                        sv_reg <= out32(leaf_val);
                        state_reg <= S_OUT;
                    end
                    else if (op_reg == ptkm_pkg::OP_LOOKUP)
                        state_reg <= S_OUT;
                    else if (leaf_cnt_reg >= CW'(CAPACITY))
                    begin
                        st_reg <= ptkm_pkg::ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        diff_reg  <= leaf_key ^ key_reg;
                        hb_reg    <= BW'(KEY_WIDTH - 1);
                        state_reg <= S_DIFF;
                    end
                end
                // one bit per cycle from the top for the highest set bit
                S_DIFF:
                begin
                    if (diff_reg[KEY_WIDTH-1])
                    begin
                        cur_reg     <= root_reg;
                        has_par_reg <= 1'b0;
                        state_reg   <= root_reg[RW-1] ? S_W2RD : S_SPLC;
                    end
                    else
                    begin
                        diff_reg <= diff_reg << 1;
                        hb_reg   <= hb_reg - BW'(1);
                    end
                end
                S_W2RD: state_reg <= S_W2;
                S_W2:
                begin
                    if (q_bit <= hb_reg)
                        state_reg <= S_SPLC;
                    else
                    begin
                        par_reg      <= cur_reg;
                        par_side_reg <= q_side;
                        par_node_reg <= br_q_reg;
                        has_par_reg  <= 1'b1;
                        cur_reg      <= q_child;
                        state_reg    <= q_child[RW-1] ? S_W2RD : S_SPLC;
                    end
                end
                S_SPLC:
                begin
                    if (!has_par_reg)
                        root_reg <= {1'b1, bi};
                    leaf_cnt_reg <= leaf_cnt_reg + CW'(1);
                    br_cnt_reg   <= br_cnt_reg + CW'(1);
                    st_reg  <= ptkm_pkg::ST_OK;
                    new_reg <= 1'b1;
                    sv_reg  <= out32(val_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (rsp.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // branches always one fewer than leaves once the map is populated
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid_reg |-> (br_cnt_reg + CW'(1) == leaf_cnt_reg))
        else $error("leaf/branch count mismatch");
    // leaf count never exceeds capacity
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        leaf_cnt_reg <= CW'(CAPACITY)) else $error("leaf count overflow");
    // a new insert is always reported ok
    a_new_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.is_new) |-> (rsp.status == ptkm_pkg::ST_OK))
        else $error("is_new with bad status");
    // a splice always advances the leaf count
    a_splice: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLC) |=> (leaf_cnt_reg == $past(leaf_cnt_reg) + CW'(1)))
        else $error("splice did not count");
`endif
endmodule

FILE: tb/tb_patricia_trie_key_map_top.sv
// ----------------------------------------------------------------------------
// tb_patricia_trie_key_map_top
// Self-checking bench for the Patricia trie key map: a directed table of
// lookups and binds, then random traffic over a small key pool so that keys
// repeat, the store fills to capacity, and full-store binds are exercised.
// Every result is compared with a behavioral trie model.
// ----------------------------------------------------------------------------
module tb_patricia_trie_key_map_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP       = 256;
    localparam int MAX_CYCLE = 1000000;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_new;
        logic [31:0] stored_value;
    } result_t;

    typedef struct {
        logic        operation;
        logic [31:0] key;
        logic [31:0] value;
        logic        has_exp;
        result_t     exp;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_cnt = 0;
    int   err_cnt = 0;

    ptkm_req_if #(.KW(32), .VW(32)) req ();
    ptkm_rsp_if rsp ();

    patricia_trie_key_map_top #(.KEY_WIDTH(32), .VALUE_WIDTH(32), .CAPACITY(CAP)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model state: trie stores and node references (bit 31 marks a branch)
    logic [31:0] leaf_key [CAP];
    logic [31:0] leaf_val [CAP];
    int          br_bit   [CAP];
    logic [31:0] br_child [CAP][2];
    logic [31:0] root_ref;
    bit          root_set;
    int          n_leaves;
    int          n_branches;
    result_t     pending_results[$];

    // Compute the result of one request and update the trie
    function automatic result_t trie_apply(logic op, logic [31:0] key, logic [31:0] val);
        result_t     res;
        logic [31:0] r;
        logic [31:0] diff;
        int          hb;
        int          slot_br;
        int          slot_side;
        int          li;
        int          bi;
        res = '{status: ptkm_pkg::ST_NOT_FOUND, is_new: 1'b0, stored_value: 32'd0};
        if (!root_set)
        begin
            if (op == ptkm_pkg::OP_LOOKUP) return res;
            li = n_leaves++;
            leaf_key[li] = key;
            leaf_val[li] = val;
            root_ref = 32'(li);
            root_set = 1'b1;
            return '{status: ptkm_pkg::ST_OK, is_new: 1'b1, stored_value: val};
        end
        r = root_ref;
        while (r[31]) r = br_child[r[30:0]][key[br_bit[r[30:0]]]];
        if (leaf_key[r] == key)
            return '{status: ptkm_pkg::ST_OK, is_new: 1'b0, stored_value: leaf_val[r]};
        if (op == ptkm_pkg::OP_LOOKUP) return res;
        if (n_leaves >= CAP || n_branches >= CAP)
        begin
            res.status = ptkm_pkg::ST_FULL;
            return res;
        end
        diff = key ^ leaf_key[r];
        hb = 0;
        for (int i = 0; i < 32; i++) if (diff[i]) hb = i;
        // descend to the splice point; slot_br = -1 means the root
        slot_br = -1;
        slot_side = 0;
        r = root_ref;
        while (r[31] && br_bit[r[30:0]] > hb)
        begin
            slot_br = r[30:0];
            slot_side = key[br_bit[r[30:0]]];
            r = br_child[slot_br][slot_side];
        end
        li = n_leaves++;
        bi = n_branches++;
        leaf_key[li] = key;
        leaf_val[li] = val;
        br_bit[bi] = hb;
        br_child[bi][key[hb]] = 32'(li);
        br_child[bi][!key[hb]] = r;
        if (slot_br < 0) root_ref = {1'b1, 31'(bi)};
        else br_child[slot_br][slot_side] = {1'b1, 31'(bi)};
        return '{status: ptkm_pkg::ST_OK, is_new: 1'b1, stored_value: val};
    endfunction

    // Directed table
    stim_t directed[$];
    result_t nf_res;

    function automatic void add_row(logic op, logic [31:0] k, logic [31:0] v,
                                    logic he, result_t e);
        stim_t s;
        s.operation = op;
        s.key = k;
        s.value = v;
        s.has_exp = he;
        s.exp = e;
        directed.push_back(s);
    endfunction

    // Sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;

    task automatic send_item(logic op, logic [31:0] k, logic [31:0] v,
                             logic he, result_t e);
        result_t pred;
        if (gap_left > 0)
        begin
            req.valid <= 1'b0;
            while (gap_left > 0)
            begin
                gap_left--;
                @(posedge clk);
            end
        end
        req.valid <= 1'b1;
        req.operation <= op;
        req.key <= k;
        req.value <= v;
        do @(posedge clk); while (!req.ready);
        pred = trie_apply(op, k, v);
        if (he && pred != e)
        begin
            $error("directed row disagrees with trie model for key %h", k);
            err_cnt++;
        end
        pending_results.push_back(pred);
        if (burst_left > 0) burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    // Receiver: stall pattern, calm stretches mixed with heavy stalls
    int rx_phase = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rx_phase <= 0;
        end
        else
        begin
            rx_phase <= rx_phase + 1;
            if ((rx_phase / 200) % 3 == 0) rsp.ready <= 1'b1;
            else rsp.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation waiting");
                err_cnt++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (rsp.status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, rsp.status);
                    err_cnt++;
                end
                if (rsp.is_new !== e.is_new)
                begin
                    $error("is_new: expected %0d, actual %0d", e.is_new, rsp.is_new);
                    err_cnt++;
                end
                if (rsp.stored_value !== e.stored_value)
                begin
                    $error("stored_value: expected %h, actual %h",
                           e.stored_value, rsp.stored_value);
                    err_cnt++;
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLE)
        begin
            $display("patricia_trie_key_map_top: mismatch");
            $finish;
        end
    end

    // Main sequence
    logic [31:0] key_pool[$];
    initial
    begin
        logic [31:0] k;
        logic        op;
        int          pool_sz;
        req.valid = 1'b0;
        req.operation = ptkm_pkg::OP_LOOKUP;
        req.key = '0;
        req.value = '0;
        root_set = 1'b0;
        n_leaves = 0;
        n_branches = 0;
        root_ref = '0;
        nf_res = '{status: ptkm_pkg::ST_NOT_FOUND, is_new: 1'b0, stored_value: 32'd0};

        // empty map, extremes, present and absent keys, top and bottom bit splits
        add_row(ptkm_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0, 1'b1, nf_res);
        add_row(ptkm_pkg::OP_BIND, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                '{status: ptkm_pkg::ST_OK, is_new: 1'b1, stored_value: 32'hFFFF_FFFF});
        add_row(ptkm_pkg::OP_BIND, 32'h0000_0000, 32'h1234_5678, 1'b1,
                '{status: ptkm_pkg::ST_OK, is_new: 1'b0, stored_value: 32'hFFFF_FFFF});
        add_row(ptkm_pkg::OP_BIND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                '{status: ptkm_pkg::ST_OK, is_new: 1'b1, stored_value: 32'h0});
        add_row(ptkm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b1,
                '{status: ptkm_pkg::ST_OK, is_new: 1'b0, stored_value: 32'h0});
        add_row(ptkm_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0, 1'b1, nf_res);
        add_row(ptkm_pkg::OP_BIND, 32'h0000_0001, 32'h5555_5555, 1'b0, nf_res);
        add_row(ptkm_pkg::OP_BIND, 32'h8000_0000, 32'hAAAA_AAAA, 1'b0, nf_res);
        add_row(ptkm_pkg::OP_BIND, 32'h7FFF_FFFF, 32'h0F0F_0F0F, 1'b0, nf_res);
        add_row(ptkm_pkg::OP_BIND, 32'hFFFF_FFFE, 32'hF0F0_F0F0, 1'b0, nf_res);
        add_row(ptkm_pkg::OP_BIND, 32'h0001_0000, 32'h8000_0001, 1'b0, nf_res);
        add_row(ptkm_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0, 1'b0, nf_res);
        add_row(ptkm_pkg::OP_LOOKUP, 32'h0000_0002, 32'h0, 1'b0, nf_res);
        add_row(ptkm_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1'b0, nf_res);
        add_row(ptkm_pkg::OP_LOOKUP, 32'h0001_0000, 32'h0, 1'b0, nf_res);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i].operation, directed[i].key, directed[i].value,
                      directed[i].has_exp, directed[i].exp);

        // random traffic; keys drawn from a pool half the time so binds repeat and fill
        foreach (directed[i]) key_pool.push_back(directed[i].key);
        for (int n = 0; n < 650; n++)
        begin
            pool_sz = key_pool.size();
            if ($urandom_range(0, 1) == 0 || pool_sz == 0)
            begin
                case ($urandom_range(0, 2))
                    0: k = $urandom();
                    1: k = key_pool[$urandom_range(0, pool_sz - 1)] ^
                           (32'h1 << $urandom_range(0, 31));
                    default: k = {4'($urandom_range(0, 15)), 28'h0} |
                                 32'($urandom_range(0, 7));
                endcase
                key_pool.push_back(k);
            end
            else
            begin
                k = key_pool[$urandom_range(0, pool_sz - 1)];
            end
            op = (n > 500) ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 9) < 7);
            send_item(op, k, $urandom(), 1'b0, nf_res);
        end
        req.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (err_cnt == 0)
            $display("patricia_trie_key_map_top: match");
        else
            $display("patricia_trie_key_map_top: mismatch");
        $finish;
    end
endmodule
